// ----- rtl/core/ssd_pkg.sv -----
// ============================================================================
// ssd_pkg
// Shared widths, types and constants of the segment distance pipeline.
// ============================================================================
`default_nettype none

package ssd_pkg;

   localparam int CoordBits = 16;
   localparam int FracBits  = 8;
   localparam int InW       = 16;
   localparam int DistW     = 25;
   localparam int Lanes     = 4;

   localparam int DiffW = CoordBits + 1;
   localparam int ProdW = 2 * DiffW;
   localparam int SumW  = ProdW + 1;
   localparam int MagW  = 2 * CoordBits + 1;
   localparam int LoW   = DiffW;
   localparam int HiW   = MagW - LoW;
   localparam int SqW   = 2 * MagW;
   localparam int NumW  = SqW + 2 * FracBits;
   localparam int DenW  = MagW;
   localparam int QW    = MagW + 2 * FracBits;
   localparam int RW    = (QW + 1) / 2;
   localparam int XW    = 2 * RW;
   localparam int SatW  = (RW > DistW) ? RW : DistW;

   localparam logic [DistW-1:0] DMax = '1;

   typedef logic signed [DiffW-1:0] diff_type;

   typedef struct packed {
      logic valid;
      logic touch;
   } side_type;

   typedef struct packed {
      logic [NumW-1:0] num;
      logic [DenW-1:0] den;
      logic            perp;
      logic [QW-1:0]   endn;
   } lane_type;

   typedef struct packed {
      logic [DistW-1:0] distance_q8;
      logic             segments_touch;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/ssd_req_if.sv -----
// ============================================================================
// ssd_req_if
// Request channel: one pair of segments per item.
// ============================================================================
`default_nettype none

interface ssd_req_if import ssd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [InW-1:0] a_start_x;
   logic signed [InW-1:0] a_start_y;
   logic signed [InW-1:0] a_end_x;
   logic signed [InW-1:0] a_end_y;
   logic signed [InW-1:0] b_start_x;
   logic signed [InW-1:0] b_start_y;
   logic signed [InW-1:0] b_end_x;
   logic signed [InW-1:0] b_end_y;

   modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, input ready);
   modport sink   (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ssd_rsp_if.sv -----
// ============================================================================
// ssd_rsp_if
// Response channel: distance and touch flag per item.
// ============================================================================
`default_nettype none

interface ssd_rsp_if import ssd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DistW-1:0] distance_q8;
   logic             segments_touch;

   modport source (output valid, distance_q8, segments_touch, input ready);
   modport sink   (input valid, distance_q8, segments_touch, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/segment_segment_distance.sv -----
// ============================================================================
// segment_segment_distance
// Distance between two 2D segments in 1/256 units, with a touch flag.
//
// req_ch carries one item: the endpoints of segments A and B, signed 16 bit.
// rsp_ch returns one item per request, in order: the distance, rounded down,
// and a flag that is set (distance zero) when the segments share a point.
// The pipeline has 5 setup stages, 49 divider stages (one quotient bit each),
// 2 min stages, 25 square-root stages (one root bit each) and the output
// buffer. One item per cycle is accepted while req_ch.ready is high. The
// whole pipeline advances together; it holds while the two-entry output
// buffer is full, and req_ch.ready is low only then, so one result may wait
// at the output while new items keep entering.
// Reset clears all valid bits and the output buffer; no item survives it.
// ============================================================================
`default_nettype none

module segment_segment_distance import ssd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ssd_req_if.sink   req_ch,
   ssd_rsp_if.source rsp_ch
);

   logic          en;
   logic          full;
   logic [InW-1:0] coord [8];
   side_type      fr_side, dv_side;
   lane_type      fr_lane [Lanes];
   logic [QW-1:0] dv_n [Lanes];
   logic          sq_valid;
   rsp_type       sq_data;

   assign en           = !full;
   assign req_ch.ready = en;

   assign coord[0] = req_ch.a_start_x;
   assign coord[1] = req_ch.a_start_y;
   assign coord[2] = req_ch.a_end_x;
   assign coord[3] = req_ch.a_end_y;
   assign coord[4] = req_ch.b_start_x;
   assign coord[5] = req_ch.b_start_y;
   assign coord[6] = req_ch.b_end_x;
   assign coord[7] = req_ch.b_end_y;

   ssd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_ch.valid),
      .coord    (coord),
      .side     (fr_side),
      .lane     (fr_lane)
   );

   ssd_div u_div (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .side_i (fr_side),
      .lane_i (fr_lane),
      .side_o (dv_side),
      .n_o    (dv_n)
   );

   ssd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .side_i    (dv_side),
      .n_i       (dv_n),
      .out_valid (sq_valid),
      .data_o    (sq_data)
   );

   ssd_obuf u_obuf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sq_valid),
      .in_data  (sq_data),
      .full     (full),
      .rsp      (rsp_ch)
   );

   a_touch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.segments_touch |-> rsp_ch.distance_q8 == '0)
      else $error("touching segments with nonzero distance");

   a_stall_has_output: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid)
      else $error("input stalled with empty output buffer");

   a_ready_after_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(req_ch.ready) |-> $past(rsp_ch.valid && rsp_ch.ready))
      else $error("input resumed without an output item taken");

endmodule

`default_nettype wire

// ----- rtl/core/ssd_front.sv -----
// ============================================================================
// ssd_front
// Differences, products, orientation tests and dividend setup, five stages.
// ============================================================================
`default_nettype none

module ssd_front import ssd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [InW-1:0] coord [8],
   output side_type       side,
   output lane_type       lane [Lanes]
);

   typedef logic signed [ProdW-1:0] prod_type;
   typedef logic signed [SumW-1:0]  sum_type;

   typedef struct packed {
      diff_type dx, dy, wx, wy, ex, ey;
   } s1_type;

   typedef struct packed {
      prod_type cra, crb, lla, llb, ta, tb, wa, wb, ea, eb;
   } s2_type;

   typedef struct packed {
      sum_type         cr;
      sum_type         t;
      logic [MagW-1:0] len2;
      logic [MagW-1:0] wn;
      logic [MagW-1:0] en;
   } s3_type;

   typedef struct packed {
      logic [2*HiW-1:0]     hh;
      logic [HiW+LoW-1:0]   hl;
      logic [2*LoW-1:0]     ll;
      logic                 perp;
      logic [DenW-1:0]      den;
      logic [QW-1:0]        endn;
   } s4_type;

   function automatic logic signed [CoordBits-1:0] cx(input logic [InW-1:0] v);
      return $signed(v[CoordBits-1:0]);
   endfunction

   logic [4:0] v_ff;
   s1_type     s1_ff [Lanes], s1_in [Lanes];
   s2_type     s2_ff [Lanes], s2_in [Lanes];
   s3_type     s3_ff [Lanes], s3_in [Lanes];
   s4_type     s4_ff [Lanes], s4_in [Lanes];
   lane_type   l5_ff [Lanes], l5_in [Lanes];
   logic       t4_ff, t4_in, t5_ff;

   // stage 1: vectors
   always_comb begin
      int s, e, p;
      for (int l = 0; l < Lanes; l++) begin
         s = (l < 2) ? 0 : 2;
         e = s + 1;
         p = (l < 2) ? 2 + l : l - 2;
         s1_in[l].dx = diff_type'(cx(coord[2*e]))   - diff_type'(cx(coord[2*s]));
         s1_in[l].dy = diff_type'(cx(coord[2*e+1])) - diff_type'(cx(coord[2*s+1]));
         s1_in[l].wx = diff_type'(cx(coord[2*p]))   - diff_type'(cx(coord[2*s]));
         s1_in[l].wy = diff_type'(cx(coord[2*p+1])) - diff_type'(cx(coord[2*s+1]));
         s1_in[l].ex = diff_type'(cx(coord[2*p]))   - diff_type'(cx(coord[2*e]));
         s1_in[l].ey = diff_type'(cx(coord[2*p+1])) - diff_type'(cx(coord[2*e+1]));
      end
   end

   // stage 2: products
   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         s2_in[l].cra = prod_type'(s1_ff[l].dx) * prod_type'(s1_ff[l].wy);
         s2_in[l].crb = prod_type'(s1_ff[l].dy) * prod_type'(s1_ff[l].wx);
         s2_in[l].lla = prod_type'(s1_ff[l].dx) * prod_type'(s1_ff[l].dx);
         s2_in[l].llb = prod_type'(s1_ff[l].dy) * prod_type'(s1_ff[l].dy);
         s2_in[l].ta  = prod_type'(s1_ff[l].wx) * prod_type'(s1_ff[l].dx);
         s2_in[l].tb  = prod_type'(s1_ff[l].wy) * prod_type'(s1_ff[l].dy);
         s2_in[l].wa  = prod_type'(s1_ff[l].wx) * prod_type'(s1_ff[l].wx);
         s2_in[l].wb  = prod_type'(s1_ff[l].wy) * prod_type'(s1_ff[l].wy);
         s2_in[l].ea  = prod_type'(s1_ff[l].ex) * prod_type'(s1_ff[l].ex);
         s2_in[l].eb  = prod_type'(s1_ff[l].ey) * prod_type'(s1_ff[l].ey);
      end
   end

   // stage 3: cross, dot, squared lengths
   always_comb begin
      sum_type acc;
      for (int l = 0; l < Lanes; l++) begin
         s3_in[l].cr = sum_type'(s2_ff[l].cra) - sum_type'(s2_ff[l].crb);
         s3_in[l].t  = sum_type'(s2_ff[l].ta) + sum_type'(s2_ff[l].tb);
         acc = sum_type'(s2_ff[l].lla) + sum_type'(s2_ff[l].llb);
         s3_in[l].len2 = acc[MagW-1:0];
         acc = sum_type'(s2_ff[l].wa) + sum_type'(s2_ff[l].wb);
         s3_in[l].wn = acc[MagW-1:0];
         acc = sum_type'(s2_ff[l].ea) + sum_type'(s2_ff[l].eb);
         s3_in[l].en = acc[MagW-1:0];
      end
   end

   // stage 4: orientation, case select, partial squares of |cross|
   always_comb begin
      logic            cz, tneg, tpos, tge, hasl, far, perp;
      logic [MagW-1:0] endsel;
      logic [SumW-1:0] magw;
      logic [HiW-1:0]  hi;
      logic [LoW-1:0]  lo;
      logic [Lanes-1:0] opos, oneg, ozr, zr;
      logic            pair_a, pair_b;
      for (int l = 0; l < Lanes; l++) begin
         cz   = (s3_ff[l].cr == '0);
         tneg = s3_ff[l].t[SumW-1];
         tpos = !tneg && (s3_ff[l].t != '0);
         tge  = !tneg && (s3_ff[l].t[SumW-2:0] >= (SumW-1)'(s3_ff[l].len2));
         hasl = (s3_ff[l].len2 != '0);
         perp = hasl && tpos && !tge;
         far  = hasl && tge;
         endsel = far ? s3_ff[l].en : s3_ff[l].wn;
         opos[l] = (!s3_ff[l].cr[SumW-1] && !cz) || (cz && tneg);
         oneg[l] = s3_ff[l].cr[SumW-1] || (cz && !tneg && (s3_ff[l].len2 < s3_ff[l].wn));
         ozr[l]  = !opos[l] && !oneg[l];
         zr[l]   = perp ? cz : (endsel == '0);
         magw = s3_ff[l].cr[SumW-1] ? -s3_ff[l].cr : s3_ff[l].cr;
         lo = magw[LoW-1:0];
         hi = magw[MagW-1:LoW];
         s4_in[l].hh   = (2*HiW)'(hi) * (2*HiW)'(hi);
         s4_in[l].hl   = (HiW+LoW)'(hi) * (HiW+LoW)'(lo);
         s4_in[l].ll   = (2*LoW)'(lo) * (2*LoW)'(lo);
         s4_in[l].perp = perp;
         s4_in[l].den  = s3_ff[l].len2;
         s4_in[l].endn = QW'(endsel) << (2 * FracBits);
      end
      pair_a = ozr[0] || ozr[1] || (opos[0] && oneg[1]) || (oneg[0] && opos[1]);
      pair_b = ozr[2] || ozr[3] || (opos[2] && oneg[3]) || (oneg[2] && opos[3]);
      t4_in  = (pair_a && pair_b) || (|zr);
   end

   // stage 5: dividend = cross^2 scaled
   always_comb begin
      logic [SqW-1:0] sq;
      for (int l = 0; l < Lanes; l++) begin
         sq = (SqW'(s4_ff[l].hh) << (2 * LoW)) + (SqW'(s4_ff[l].hl) << (LoW + 1))
            + SqW'(s4_ff[l].ll);
         l5_in[l].num  = s4_ff[l].perp ? (NumW'(sq) << (2 * FracBits)) : '0;
         l5_in[l].den  = s4_ff[l].perp ? s4_ff[l].den : DenW'(1);
         l5_in[l].perp = s4_ff[l].perp;
         l5_in[l].endn = s4_ff[l].endn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         l5_ff <= l5_in;
         t4_ff <= t4_in;
         t5_ff <= t4_ff;
      end
   end

   assign side = {v_ff[4], t5_ff};
   assign lane = l5_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ssd_div.sv -----
// ============================================================================
// ssd_div
// Restoring divider, one quotient bit per stage, four lanes in step.
// ============================================================================
`default_nettype none

module ssd_div import ssd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  side_type      side_i,
   input  lane_type      lane_i [Lanes],
   output side_type      side_o,
   output logic [QW-1:0] n_o [Lanes]
);

   typedef struct packed {
      logic [DenW-1:0] rem;
      logic [QW-1:0]   bits;
      logic [DenW-1:0] den;
      logic [QW-1:0]   q;
      logic            perp;
      logic [QW-1:0]   endn;
   } div_type;

   function automatic div_type div_step(div_type s);
      logic [DenW:0] r2;
      logic          ge;
      div_type       o;
      r2 = {s.rem, s.bits[QW-1]};
      ge = (r2 >= {1'b0, s.den});
      o = s;
      o.rem  = ge ? DenW'(r2 - {1'b0, s.den}) : r2[DenW-1:0];
      o.bits = s.bits << 1;
      o.q    = {s.q[QW-2:0], ge};
      return o;
   endfunction

   div_type  st_ff [QW][Lanes];
   div_type  st_in [QW][Lanes];
   side_type sd_ff [QW];

   always_comb begin
      div_type e;
      for (int l = 0; l < Lanes; l++) begin
         e.rem  = lane_i[l].num[NumW-1:QW];
         e.bits = lane_i[l].num[QW-1:0];
         e.den  = lane_i[l].den;
         e.q    = '0;
         e.perp = lane_i[l].perp;
         e.endn = lane_i[l].endn;
         st_in[0][l] = div_step(e);
         for (int s = 1; s < QW; s++) begin
            st_in[s][l] = div_step(st_ff[s-1][l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < QW; s++) begin
            sd_ff[s] <= '0;
         end
      end else if (en) begin
         sd_ff[0] <= side_i;
         for (int s = 1; s < QW; s++) begin
            sd_ff[s] <= sd_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         n_o[l] = st_ff[QW-1][l].perp ? st_ff[QW-1][l].q : st_ff[QW-1][l].endn;
      end
   end

   assign side_o = sd_ff[QW-1];

endmodule

`default_nettype wire

// ----- rtl/core/ssd_sqrt.sv -----
// ============================================================================
// ssd_sqrt
// Minimum over the four lanes, then a digit-by-digit integer square root.
// ============================================================================
`default_nettype none

module ssd_sqrt import ssd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  side_type      side_i,
   input  logic [QW-1:0] n_i [Lanes],
   output logic          out_valid,
   output rsp_type       data_o
);

   localparam int Depth = RW + 2;

   typedef struct packed {
      logic [XW-1:0] x;
      logic [XW-1:0] r;
   } rt_type;

   side_type      sd_ff [Depth];
   logic [QW-1:0] m1_ff [2];
   logic [QW-1:0] m2_ff;
   rt_type        rt_ff [RW], rt_in [RW];
   logic [RW-1:0] root;
   logic [SatW-1:0] wide;

   always_comb begin
      rt_type        src;
      logic [XW-1:0] one, tt;
      for (int k = 0; k < RW; k++) begin
         if (k == 0) begin
            src.x = XW'(m2_ff);
            src.r = '0;
         end else begin
            src = rt_ff[k-1];
         end
         one = XW'(1) << (2 * (RW - 1 - k));
         tt  = src.r + one;
         if (src.x >= tt) begin
            rt_in[k].x = src.x - tt;
            rt_in[k].r = (src.r >> 1) + one;
         end else begin
            rt_in[k].x = src.x;
            rt_in[k].r = src.r >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Depth; k++) begin
            sd_ff[k] <= '0;
         end
      end else if (en) begin
         sd_ff[0] <= side_i;
         for (int k = 1; k < Depth; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff[0] <= (n_i[1] < n_i[0]) ? n_i[1] : n_i[0];
         m1_ff[1] <= (n_i[3] < n_i[2]) ? n_i[3] : n_i[2];
         m2_ff    <= (m1_ff[1] < m1_ff[0]) ? m1_ff[1] : m1_ff[0];
         rt_ff    <= rt_in;
      end
   end

   assign root = rt_ff[RW-1].r[RW-1:0];
   assign wide = SatW'(root);

   always_comb begin
      data_o.segments_touch = sd_ff[Depth-1].touch;
      if (sd_ff[Depth-1].touch) begin
         data_o.distance_q8 = '0;
      end else if (wide > SatW'(DMax)) begin
         data_o.distance_q8 = DMax;
      end else begin
         data_o.distance_q8 = wide[DistW-1:0];
      end
   end

   assign out_valid = sd_ff[Depth-1].valid;

endmodule

`default_nettype wire

// ----- rtl/core/ssd_obuf.sv -----
// ============================================================================
// ssd_obuf
// Two-entry output buffer; decouples the pipeline from the response sink.
// ============================================================================
`default_nettype none

module ssd_obuf import ssd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  rsp_type    in_data,
   output logic       full,
   ssd_rsp_if.source  rsp
);

   localparam logic [1:0] Slots = 2'd2;

   rsp_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign full = (cnt_ff == Slots);
   assign push = in_valid && !full;
   assign pop  = rsp.valid && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end

   assign rsp.valid          = (cnt_ff != '0);
   assign rsp.distance_q8    = mem_ff[rp_ff].distance_q8;
   assign rsp.segments_touch = mem_ff[rp_ff].segments_touch;

endmodule

`default_nettype wire

// ----- tb/ssd_tb_if.sv -----
// ============================================================================
// ssd_tb_if
// Testbench-side note: channel interfaces come from the RTL interface files.
// ============================================================================
`default_nettype none

package ssd_tb_pkg;
   import ssd_pkg::*;

   typedef struct {
      logic signed [InW-1:0] c[8];
   } seg_pair_type;
endpackage

`default_nettype wire

// ----- tb/tb_segment_segment_distance.sv -----
// ============================================================================
// tb_segment_segment_distance
// Streams segment pairs through the distance pipeline and checks every item
// against an exact integer model of distance and touch flag.
// ============================================================================
`default_nettype none

module tb_segment_segment_distance;
   timeunit 1ns;
   timeprecision 1ps;

   import ssd_pkg::*;
   import ssd_tb_pkg::*;

   localparam int LimitCycles = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssd_req_if req_ch ();
   ssd_rsp_if rsp_ch ();

   segment_segment_distance i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   seg_pair_type pending_q[$];
   rsp_type      expected_q[$];
   int           error_count = 0;
   int           cycle_count = 0;
   bit           calm = 1'b0;
   bit           hold_off = 1'b0;
   bit           req_fire = 1'b0;
   int           req_gap = 0;
   int           rsp_gap = 0;

   typedef struct {
      longint x;
      longint y;
   } point_type;

   function automatic int orient_code(point_type a, point_type b, point_type c);
      longint bx, by, cx, cy, cr;
      bx = b.x - a.x; by = b.y - a.y;
      cx = c.x - a.x; cy = c.y - a.y;
      cr = bx * cy - by * cx;
      if (cr > 0) return 1;
      if (cr < 0) return -1;
      if (bx * cx + by * cy < 0) return 2;
      if (bx * bx + by * by < cx * cx + cy * cy) return -2;
      return 0;
   endfunction

   // largest q with q*q*den <= num * 2^(2*FracBits)
   function automatic longint unsigned root_q8(logic [127:0] num, logic [127:0] den);
      logic [127:0] rhs, cand, q;
      rhs = num << (2 * FracBits);
      q = 0;
      for (int i = 2 * CoordBits + FracBits + 2; i >= 0; i--) begin
         cand = q | (128'd1 << i);
         if (cand * cand * den <= rhs) q = cand;
      end
      return q[63:0];
   endfunction

   function automatic longint unsigned point_to_seg(point_type a, point_type b,
                                                    point_type p, ref bit zero);
      longint dx, dy, wx, wy, len2, t, c, ex, ey;
      logic [127:0] n;
      dx = b.x - a.x; dy = b.y - a.y;
      wx = p.x - a.x; wy = p.y - a.y;
      len2 = dx * dx + dy * dy;
      t = wx * dx + wy * dy;
      if (len2 > 0 && t > 0 && t < len2) begin
         c = dx * wy - dy * wx;
         if (c < 0) c = -c;
         if (c == 0) zero = 1'b1;
         n = 128'(c) * 128'(c);
         return root_q8(n, 128'(len2));
      end
      if (len2 > 0 && t >= len2) begin
         ex = p.x - b.x; ey = p.y - b.y;
         n = 128'(ex * ex + ey * ey);
      end else begin
         n = 128'(wx * wx + wy * wy);
      end
      if (n == 0) zero = 1'b1;
      return root_q8(n, 128'd1);
   endfunction

   function automatic rsp_type predict_distance(seg_pair_type s);
      point_type a0, a1, b0, b1;
      bit zero, touch;
      longint unsigned d, e;
      rsp_type r;
      a0.x = longint'(s.c[0]); a0.y = longint'(s.c[1]);
      a1.x = longint'(s.c[2]); a1.y = longint'(s.c[3]);
      b0.x = longint'(s.c[4]); b0.y = longint'(s.c[5]);
      b1.x = longint'(s.c[6]); b1.y = longint'(s.c[7]);
      zero = 1'b0;
      touch = orient_code(a0, a1, b0) * orient_code(a0, a1, b1) <= 0 &&
              orient_code(b0, b1, a0) * orient_code(b0, b1, a1) <= 0;
      d = point_to_seg(a0, a1, b0, zero);
      e = point_to_seg(a0, a1, b1, zero); if (e < d) d = e;
      e = point_to_seg(b0, b1, a0, zero); if (e < d) d = e;
      e = point_to_seg(b0, b1, a1, zero); if (e < d) d = e;
      if (zero) touch = 1'b1;
      if (touch) d = 0;
      if (d > longint'(DMax)) d = longint'(DMax);
      r.distance_q8    = d[DistW-1:0];
      r.segments_touch = touch;
      return r;
   endfunction

   function automatic logic signed [InW-1:0] rand_coord(int mode);
      case (mode)
         0: return InW'($urandom);
         1: return InW'($urandom_range(0, 40) - 20);
         2: return $urandom_range(0, 1) ? InW'(16'sh7fff - $urandom_range(0, 3))
                                        : InW'(16'sh8000 + $urandom_range(0, 3));
         default: return InW'($urandom_range(0, 2000) - 1000);
      endcase
   endfunction

   task automatic add_pair(input int c0, c1, c2, c3, c4, c5, c6, c7);
      seg_pair_type s;
      s.c[0] = InW'(c0); s.c[1] = InW'(c1); s.c[2] = InW'(c2); s.c[3] = InW'(c3);
      s.c[4] = InW'(c4); s.c[5] = InW'(c5); s.c[6] = InW'(c6); s.c[7] = InW'(c7);
      pending_q.push_back(s);
   endtask

   task automatic add_random(int count);
      seg_pair_type s;
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 3);
         for (int k = 0; k < 8; k++) s.c[k] = rand_coord(mode);
         case ($urandom_range(0, 7))
            0: begin s.c[2] = s.c[0]; s.c[3] = s.c[1]; end
            1: begin s.c[4] = s.c[2]; s.c[5] = s.c[3]; end
            2: begin
               s.c[4] = s.c[0] + (s.c[2] - s.c[0]) / 2;
               s.c[5] = s.c[1] + (s.c[3] - s.c[1]) / 2;
            end
            default: ;
         endcase
         pending_q.push_back(s);
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_fire) void'(pending_q.pop_front());
         if (req_gap > 0) req_gap <= req_gap - 1;
         if ((!req_ch.valid || req_fire) &&
             (!calm && req_gap == 0 && $urandom_range(0, 15) == 0)) begin
            req_gap <= $urandom_range(1, 12);
            req_ch.valid <= 1'b0;
         end else if (!req_ch.valid || req_fire) begin
            if (pending_q.size() > 0 && !hold_off && (req_gap == 0 || calm)) begin
               req_ch.valid <= 1'b1;
               req_ch.a_start_x <= pending_q[0].c[0];
               req_ch.a_start_y <= pending_q[0].c[1];
               req_ch.a_end_x   <= pending_q[0].c[2];
               req_ch.a_end_y   <= pending_q[0].c[3];
               req_ch.b_start_x <= pending_q[0].c[4];
               req_ch.b_start_y <= pending_q[0].c[5];
               req_ch.b_end_x   <= pending_q[0].c[6];
               req_ch.b_end_y   <= pending_q[0].c[7];
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         rsp_gap <= $urandom_range(1, 12);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type got, want;
      cycle_count <= cycle_count + 1;
      req_fire <= !reset && req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seg_pair_type s;
            s.c[0] = req_ch.a_start_x; s.c[1] = req_ch.a_start_y;
            s.c[2] = req_ch.a_end_x;   s.c[3] = req_ch.a_end_y;
            s.c[4] = req_ch.b_start_x; s.c[5] = req_ch.b_start_y;
            s.c[6] = req_ch.b_end_x;   s.c[7] = req_ch.b_end_y;
            expected_q.push_back(predict_distance(s));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.distance_q8    = rsp_ch.distance_q8;
            got.segments_touch = rsp_ch.segments_touch;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected item distance_q8=%0d touch=%0b",
                        $time, got.distance_q8, got.segments_touch);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.distance_q8 !== want.distance_q8) begin
                  $display("%0t: distance_q8 expected %0d actual %0d",
                           $time, want.distance_q8, got.distance_q8);
                  error_count++;
               end
               if (got.segments_touch !== want.segments_touch) begin
                  $display("%0t: segments_touch expected %0b actual %0b",
                           $time, want.segments_touch, got.segments_touch);
                  error_count++;
               end
            end
         end
      end
      if (cycle_count > LimitCycles) begin
         $display("segment_segment_distance verification failed");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.a_start_x = '0; req_ch.a_start_y = '0;
      req_ch.a_end_x = '0;   req_ch.a_end_y = '0;
      req_ch.b_start_x = '0; req_ch.b_start_y = '0;
      req_ch.b_end_x = '0;   req_ch.b_end_y = '0;
      rsp_ch.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b1;
      @(negedge clock);
      reset = 1'b0;

      // crossing, parallel, collinear overlap and touch, points, extremes
      add_pair(0, 0, 10, 10, 0, 10, 10, 0);
      add_pair(0, 0, 10, 0, 0, 5, 10, 5);
      add_pair(0, 0, 10, 0, 5, 0, 20, 0);
      add_pair(0, 0, 10, 0, 10, 0, 20, 0);
      add_pair(0, 0, 10, 0, 11, 0, 20, 0);
      add_pair(3, 4, 3, 4, 0, 0, 0, 0);
      add_pair(7, 7, 7, 7, 7, 7, 7, 7);
      add_pair(5, 0, 5, 0, 0, 0, 10, 0);
      add_pair(5, 3, 5, 3, 0, 0, 10, 0);
      add_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
      add_pair(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768);
      add_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
      add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      add_pair(0, 0, 10, 0, 5, 1, 5, 9);
      add_pair(0, 0, 10, 0, 15, 3, 20, 9);
      add_pair(-1, -1, -1, -1, -1, -1, -1, -1);
      add_pair(0, 0, 1, 1, 1, 0, 2, 1);
      add_pair(0, 0, 32767, 1, 0, 1, 32767, 2);
      add_pair(0, 0, 10, 10, 5, 5, 5, 5);
      add_random(200);
      while (pending_q.size() > 0) @(negedge clock);

      // drain before resuming
      hold_off = 1'b1;
      while (expected_q.size() > 0) @(negedge clock);
      hold_off = 1'b0;
      add_random(330);
      while (pending_q.size() > 0) @(negedge clock);

      calm = 1'b1;
      add_random(100);
      while (pending_q.size() > 0 || req_ch.valid) @(negedge clock);
      while (expected_q.size() > 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (error_count == 0) begin
         $display("segment_segment_distance verification clean");
      end else begin
         $display("segment_segment_distance verification failed");
      end
      $finish;
   end
endmodule

`default_nettype wire
